/* sv/mfat_pkg.sv */
// Shared types and constants for the motor feedback angle tracker.
// No dependencies; the state memory, update logic and top level import this package.
package mfat_pkg;

  localparam int NUM_MOTORS     = 8;
  localparam int HISTORY_DEPTH  = 16;
  localparam int ENC_BITS       = 13;
  localparam int ENCODER_COUNTS = 1 << ENC_BITS;
  localparam int MOTOR_W        = 3;
  localparam int ID_W           = 11;
  localparam int CALIB_W        = 8;
  localparam int CNT_W          = 9;
  localparam int FILL_W         = 5;
  localparam int TOTAL_W        = 32;
  localparam int ROUND_W        = TOTAL_W - ENC_BITS;

  typedef logic [MOTOR_W-1:0] motor_t;

  // Per-motor tracking state, one memory word per motor.
  typedef struct packed {
    logic [CNT_W-1:0]          frame_cnt;
    logic [ENC_BITS-1:0]       last_enc;
    logic signed [TOTAL_W-1:0] total;
    logic [FILL_W-1:0]         fill;
  } motor_state_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BASE_ID = 1'b0,
    REG_CALIB   = 1'b1
  } reg_index_t;

endpackage

/* sv/mfat_state_mem.sv */
// Per-motor state memory: one write port, one registered read port.
// Depends on mfat_pkg; per-entry valid bits make unwritten entries read as zero.
module mfat_state_mem (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  mfat_pkg::motor_t      wr_addr,
  input  mfat_pkg::motor_state_t wr_data,
  input  mfat_pkg::motor_t      rd_addr,
  output mfat_pkg::motor_state_t rd_data
);
  import mfat_pkg::*;

  motor_state_t            mem [NUM_MOTORS];
  logic [NUM_MOTORS-1:0]   valid;
  motor_state_t            mem_q;
  logic                    q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      q_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  assign rd_data = q_valid ? mem_q : '0;

endmodule

/* sv/mfat_update.sv */
// Next-state logic for one motor: calibration sequencing, unwrap, saturating total.
// Depends on mfat_pkg.
module mfat_update (
  input  mfat_pkg::motor_state_t st,
  input  logic [mfat_pkg::ENC_BITS-1:0] enc,
  input  logic [mfat_pkg::CALIB_W-1:0]  calib,
  output mfat_pkg::motor_state_t nxt,
  output logic                   emit
);
  import mfat_pkg::*;

  localparam logic signed [ENC_BITS+1:0] SPAN = $signed({2'b01, {ENC_BITS{1'b0}}});

  logic [CNT_W-1:0]            calib_ext;
  logic signed [ENC_BITS+1:0]  d;
  logic signed [ENC_BITS+1:0]  alt;
  logic signed [ENC_BITS+1:0]  d_abs;
  logic signed [ENC_BITS+1:0]  alt_abs;
  logic signed [ENC_BITS+1:0]  step;
  logic signed [TOTAL_W:0]     sum;
  logic signed [TOTAL_W-1:0]   sum_sat;

  assign calib_ext = {{(CNT_W-CALIB_W){1'b0}}, calib};

  always_comb begin
    d       = $signed({2'b00, enc}) - $signed({2'b00, st.last_enc});
    alt     = (enc < st.last_enc) ? d + SPAN : d - SPAN;
    d_abs   = d[ENC_BITS+1] ? -d : d;
    alt_abs = alt[ENC_BITS+1] ? -alt : alt;
    // tie keeps the direct difference
    step    = (alt_abs < d_abs) ? alt : d;
    sum     = {st.total[TOTAL_W-1], st.total}
            + {{(TOTAL_W-ENC_BITS-1){step[ENC_BITS+1]}}, step};
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      sum_sat = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      sum_sat = sum[TOTAL_W-1:0];
    end
  end

  always_comb begin
    nxt  = st;
    emit = 1'b0;
    priority if (st.frame_cnt < calib_ext) begin
      nxt.frame_cnt = st.frame_cnt + CNT_W'(1);
    end else if (st.frame_cnt == calib_ext) begin
      nxt.frame_cnt = st.frame_cnt + CNT_W'(1);
      nxt.last_enc  = enc;
    end else begin
      emit         = 1'b1;
      nxt.last_enc = enc;
      nxt.total    = sum_sat;
      nxt.fill     = (st.fill < FILL_W'(HISTORY_DEPTH)) ? st.fill + FILL_W'(1) : st.fill;
    end
  end

endmodule

/* sv/motor_feedback_angle_tracker.sv */
// Top level of the motor feedback angle tracker: input decode, state read
// stage with bypass, output register. Depends on mfat_pkg, mfat_state_mem, mfat_update.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[63:0]  one feedback frame
//  m_      | out | m_tvalid/m_tready  | m_tdata[103:0] one decoded motor update
//  cfg_    | in  | cfg_we (no wait)   | cfg_index, cfg_data  register write
//
// Rate: one frame per cycle while m_ is not stalled; a result reaches m_ after its
//   request is accepted (state memory read, then update and output register).
// The single-port read of the per-motor state memory sets that rate; a bypass
//   register forwards a write-back to a frame of the same motor right behind it.
// Reset: synchronous; valid bits clear all per-motor state at once, no sweep.
// Stalls: a held result stops a frame that would make a result in the read
//   stage, and the input behind it; frames for other ids, ignored or
//   calibration frames pass the read stage without waiting.
module motor_feedback_angle_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_id[10:0], encoder_raw[23:11], speed_raw[39:24],
  // current_raw[55:40], temperature_raw[63:56]
  input  logic [63:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // motor_index[2:0], motor_speed[18:3], current_value[34:19], temperature[42:35],
  // angle_accum[74:43], round_count[93:75], history_fill[98:94], zero[103:99]
  output logic [103:0] m_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  import mfat_pkg::*;

  // configuration
  logic [ID_W-1:0]    base_id;
  logic [CALIB_W-1:0] calib_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id      <= ID_W'(513);
      calib_frames <= CALIB_W'(50);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_ID: base_id      <= cfg_data;
        REG_CALIB:   calib_frames <= cfg_data[CALIB_W-1:0];
      endcase
    end
  end

  // input field split and id match
  logic [ID_W-1:0]     in_fid;
  logic [ENC_BITS-1:0] in_enc;
  logic [15:0]         in_speed;
  logic [15:0]         in_current;
  logic [7:0]          in_temp;
  logic [ID_W:0]       id_diff;
  logic                in_match;
  motor_t              in_motor;
  logic                in_accept;

  assign in_fid     = s_tdata[10:0];
  assign in_enc     = s_tdata[23:11];
  assign in_speed   = s_tdata[39:24];
  assign in_current = s_tdata[55:40];
  assign in_temp    = s_tdata[63:56];

  assign id_diff  = {1'b0, in_fid} - {1'b0, base_id};
  assign in_match = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NUM_MOTORS));
  assign in_motor = id_diff[MOTOR_W-1:0];
  assign in_accept = s_tvalid && s_tready;

  // read stage: frame waits here while its motor state comes out of memory
  logic                s1_valid;
  motor_t              s1_motor;
  logic [ENC_BITS-1:0] s1_enc;
  logic [15:0]         s1_speed;
  logic [15:0]         s1_current;
  logic [7:0]          s1_temp;
  logic                s1_adv;
  logic                s1_hold;

  motor_state_t mem_rd;
  motor_state_t cur_state;
  motor_state_t upd_next;
  logic         upd_emit;
  motor_t       rd_addr;

  // bypass of the write made at the same edge as the pending read
  logic         byp_valid;
  motor_t       byp_motor;
  motor_state_t byp_state;

  // output register
  logic                      out_valid;
  logic                      out_free;
  logic                      out_load;
  motor_t                    out_motor;
  logic [15:0]               out_speed;
  logic [15:0]               out_current;
  logic [7:0]                out_temp;
  logic signed [TOTAL_W-1:0] out_total;
  logic [FILL_W-1:0]         out_fill;
  logic signed [ROUND_W-1:0] out_round;

  assign out_free = !out_valid || m_tready;
  assign s1_adv   = s1_valid && (!upd_emit || out_free);
  assign s1_hold  = s1_valid && !s1_adv;
  assign s_tready = !s1_valid || s1_adv;
  assign out_load = s1_adv && upd_emit;

  // a held frame re-reads its own entry so later writes stay visible
  assign rd_addr = s1_hold ? s1_motor : in_motor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid && in_match;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_motor   <= in_motor;
      s1_enc     <= in_enc;
      s1_speed   <= in_speed;
      s1_current <= in_current;
      s1_temp    <= in_temp;
    end
  end

  mfat_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_adv),
    .wr_addr (s1_motor),
    .wr_data (upd_next),
    .rd_addr (rd_addr),
    .rd_data (mem_rd)
  );

  assign cur_state = (byp_valid && (byp_motor == s1_motor)) ? byp_state : mem_rd;

  mfat_update u_upd (
    .st    (cur_state),
    .enc   (s1_enc),
    .calib (calib_frames),
    .nxt   (upd_next),
    .emit  (upd_emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= s1_adv;
    end
    byp_motor <= s1_motor;
    byp_state <= upd_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_motor   <= s1_motor;
      out_speed   <= s1_speed;
      out_current <= s1_current;
      out_temp    <= s1_temp;
      out_total   <= upd_next.total;
      out_fill    <= upd_next.fill;
    end
  end

  // divide by the encoder span, truncated toward zero: floor plus one for a
  // negative total with a nonzero remainder
  assign out_round = out_total[TOTAL_W-1:ENC_BITS]
                   + ROUND_W'(out_total[TOTAL_W-1] && (out_total[ENC_BITS-1:0] != '0));

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_fill, out_round, out_total, out_temp,
                     out_current, out_speed, out_motor};

endmodule

/* sv/mfat_checker.sv */
// Port-level checks for the motor feedback angle tracker, bound to the top level.
// Depends on motor_feedback_angle_tracker port names only.
module mfat_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);

  // nothing pending right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // read stage empty after reset, so requests are taken
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // history fill of a result is between one and the ring depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[98:94] != 5'd0) && (m_tdata[98:94] <= 5'd16))
    else $error("history fill out of range");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[103:99] == 5'd0))
    else $error("nonzero pad bits");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind motor_feedback_angle_tracker mfat_checker u_mfat_checker (.*);
